// ===== src/temporal_adjacency_log_encoder_unit_macros.svh =====
// assertion macros used by the encoder's top level
`ifndef TEMPORAL_ADJACENCY_LOG_ENCODER_UNIT_MACROS_SVH
`define TEMPORAL_ADJACENCY_LOG_ENCODER_UNIT_MACROS_SVH

// check that is switched off while reset is high
`define TALE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also holds while reset is high
`define TALE_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/tale_pkg.sv =====
// shared types and constants of the temporal adjacency log encoder
package tale_pkg;

   localparam int unsigned NODE_W      = 30;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned RUN_W       = 6;
   localparam int unsigned MAX_RUN_DEF = 62;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   // prev source value meaning no source seen yet
   localparam logic [NODE_W:0] NO_SOURCE = '1;

   // register index of node_count
   localparam logic [0:0] REG_NODE_COUNT = 1'b0;

   localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(1);

   typedef enum logic {
      FUNC_EDGE   = 1'b0,
      FUNC_FINISH = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      KIND_MARK = 2'd0,
      KIND_TIME = 2'd1,
      KIND_DEST = 2'd2,
      KIND_STAT = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_ORDER = 2'd1,
      ERR_RANGE = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      PH_MARK = 2'd0,
      PH_TIME = 2'd1,
      PH_DEST = 2'd2,
      PH_STAT = 2'd3
   } phase_type;

   typedef struct packed {
      func_type          func;
      logic [NODE_W-1:0] from_node;
      logic [NODE_W-1:0] to_node;
      logic [NODE_W-1:0] event_time;
   } req_type;

   typedef struct packed {
      kind_type                 kind;
      logic signed [WORD_W-1:0] word;
      logic                     last;
      logic                     resend;
      logic                     done_res;
      err_type                  error;
      logic [WORD_W-1:0]        total_words;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [NODE_W-1:0] mark_start;
      logic [RUN_W-1:0]  mark_cnt;
      logic              time_en;
      logic [WORD_W-1:0] time_word;
      logic              dest_en;
      logic [NODE_W-1:0] dest;
      logic              stat_en;
      logic              done;
      err_type           err;
      logic              again;
   } cmd_type;

endpackage

// ===== src/temporal_adjacency_log_encoder_unit.sv =====
// Temporal adjacency log encoder, top level.
// Request channel (req_): one word per temporal edge, sorted by source and
// then time, or a finish word. Response channel (rsp_): one log word a cycle
// unless stalled: node markers, time, destination and status words; last
// marks the final word of a request, resend asks for the same request again.
// Register port (csr_): node_count at byte address 0, read and write.
// The first word of a request passes through the command queue and then
// the output register. A request has markers (at most MaxRun), plus an
// optional time word, plus the destination word or one status word; one
// that is to be resent has markers only. The rate is set by the back-end
// word sequencer, which writes one word per cycle to the output register
// while rsp_stall is low. A two-entry command queue lets the front accept
// requests while the back end is busy; req_stall rises when that queue is
// full. A high rsp_stall holds the output word; the queue then fills and
// stalls the request side.
// Reset (synchronous) empties the queue, forgets all sources and times,
// clears the word count and sets node_count to 1.
`include "temporal_adjacency_log_encoder_unit_macros.svh"

module temporal_adjacency_log_encoder_unit #(
   parameter int unsigned MaxRun = tale_pkg::MAX_RUN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  tale_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output tale_pkg::rsp_type                 rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tale_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tale_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tale_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import tale_pkg::*;

   logic [NODE_W-1:0] node_count_ff, node_count_in;
   logic              csr_wr, csr_hit;
   logic              q_full, push, pop, head_valid;
   cmd_type           cmd, head;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_NODE_COUNT);

   always_comb begin
      node_count_in = node_count_ff;
      if (csr_wr && csr_hit) begin
         node_count_in = csr_pwdata[NODE_W-1:0];
      end
      csr_prdata = csr_hit ? CSR_DATA_W'(node_count_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   assign req_stall = q_full;

   tale_front #(
      .MaxRun(MaxRun)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .node_count (node_count_ff),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .q_full     (q_full),
      .push       (push),
      .cmd        (cmd)
   );

   tale_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (cmd),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (q_full)
   );

   tale_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // status words carry no log word
   `TALE_ASSERT(a_stat_zero, (rsp_valid && rsp_data.kind == KIND_STAT) |-> (rsp_data.word == '0), "status word not zero")
   // finish completion ends its request and never asks for a resend
   `TALE_ASSERT(a_done_final, (rsp_valid && rsp_data.done_res) |-> (rsp_data.kind == KIND_STAT && rsp_data.last && !rsp_data.resend), "bad finish status")
   // word count never runs backward
   `TALE_ASSERT(a_count_mono, (rsp_valid && !rsp_stall) |=> (!rsp_valid || rsp_data.total_words >= $past(rsp_data.total_words)), "word count decreased")
   // output is empty right after reset
   `TALE_ASSERT_RST(a_reset_idle, reset |=> !rsp_valid, "output valid after reset")

endmodule

// ===== src/tale_front.sv =====
// front end: checks and classifies each word, owns source and time tracking
module tale_front #(
   parameter int unsigned MaxRun = tale_pkg::MAX_RUN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tale_pkg::NODE_W-1:0]   node_count,
   input  logic                          req_valid,
   input  tale_pkg::req_type             req_data,
   input  logic                          q_full,
   output logic                          push,
   output tale_pkg::cmd_type             cmd
);
   import tale_pkg::*;

   localparam logic [NODE_W:0]   RUN_LIM  = (NODE_W+1)'(MaxRun);
   localparam logic [RUN_W-1:0]  RUN_CNT  = RUN_W'(MaxRun);
   localparam logic [NODE_W-1:0] RUN_STEP = NODE_W'(MaxRun - 1);

   logic [NODE_W:0]   prev_src_ff, prev_src_in;
   logic [NODE_W-1:0] prev_time_ff, prev_time_in;
   logic              ptv_ff, ptv_in;

   logic              none, is_fin, err_order, err_range, err_any;
   logic              need_pos, over;
   logic [NODE_W-1:0] first_v;
   logic [NODE_W:0]   hi, need, src_cap;
   logic [RUN_W-1:0]  cnt;

   // classification against current state
   always_comb begin
      none      = (prev_src_ff == NO_SOURCE);
      first_v   = none ? '0 : prev_src_ff[NODE_W-1:0] + NODE_W'(1);
      is_fin    = (req_data.func == FUNC_FINISH);
      err_order = !is_fin && !none && ({1'b0, req_data.from_node} < prev_src_ff);
      err_range = !is_fin && !err_order && (req_data.from_node >= node_count);
      err_any   = err_order || err_range;
      // one past the last node that needs a marker
      hi        = is_fin ? {1'b0, node_count}
                         : {1'b0, req_data.from_node} + (NODE_W+1)'(1);
      need_pos  = (hi > {1'b0, first_v});
      need      = hi - {1'b0, first_v};
      over      = !err_any && need_pos && (need > RUN_LIM);
      if (err_any || !need_pos) begin
         cnt = '0;
      end else if (over) begin
         cnt = RUN_CNT;
      end else begin
         cnt = need[RUN_W-1:0];
      end
      src_cap   = over ? {1'b0, first_v + RUN_STEP} : hi - (NODE_W+1)'(1);
   end

   // command for the back end
   always_comb begin
      cmd.mark_start = first_v;
      cmd.mark_cnt   = cnt;
      cmd.again      = over;
      cmd.dest_en    = !is_fin && !err_any && !over;
      cmd.time_en    = !is_fin && !err_any && !over &&
                       ((cnt != '0) || !ptv_ff || (req_data.event_time != prev_time_ff));
      cmd.time_word  = WORD_W'({1'b0, node_count} + {1'b0, req_data.event_time});
      cmd.dest       = req_data.to_node;
      cmd.stat_en    = err_any || (is_fin && !over);
      cmd.done       = is_fin && !over;
      if (err_order) begin
         cmd.err = ERR_ORDER;
      end else if (err_range) begin
         cmd.err = ERR_RANGE;
      end else begin
         cmd.err = ERR_NONE;
      end
   end

   assign push = req_valid && !q_full;

   // state after this word
   always_comb begin
      prev_src_in  = prev_src_ff;
      prev_time_in = prev_time_ff;
      ptv_in       = ptv_ff;
      if (push && !err_any) begin
         if (cnt != '0) begin
            prev_src_in = src_cap;
            ptv_in      = 1'b0;
         end
         if (cmd.dest_en) begin
            ptv_in       = 1'b1;
            prev_time_in = req_data.event_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_src_ff  <= NO_SOURCE;
         prev_time_ff <= '0;
         ptv_ff       <= 1'b0;
      end else begin
         prev_src_ff  <= prev_src_in;
         prev_time_ff <= prev_time_in;
         ptv_ff       <= ptv_in;
      end
   end

endmodule

// ===== src/tale_queue.sv =====
// short command queue between front and back end
module tale_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tale_pkg::cmd_type  push_data,
   input  logic               pop,
   output tale_pkg::cmd_type  head,
   output logic               head_valid,
   output logic               full
);
   import tale_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   cmd_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign head       = mem_ff[rd_ptr_ff];
   assign head_valid = (cnt_ff != '0);
   assign full       = (cnt_ff == FULL_CNT);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/tale_back.sv =====
// back end: steps through the words of each command, one word a cycle unless stalled
module tale_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  tale_pkg::cmd_type  head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tale_pkg::rsp_type  rsp_data
);
   import tale_pkg::*;

   logic              started_ff, started_in;
   phase_type         phase_ff, phase_in;
   logic [NODE_W-1:0] v_ff, v_in;
   logic [RUN_W-1:0]  rem_ff, rem_in;
   logic [WORD_W-1:0] wcnt_ff, wcnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   phase_type         first_ph, cur_ph, nxt_ph;
   logic [NODE_W-1:0] cur_v;
   logic [RUN_W-1:0]  cur_rem;
   logic              more, emit, counts;
   logic [WORD_W-1:0] wcnt_inc;

   assign emit = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = emit && !more;

   // first phase of a fresh command
   always_comb begin
      if (head.mark_cnt != '0) begin
         first_ph = PH_MARK;
      end else if (head.time_en) begin
         first_ph = PH_TIME;
      end else if (head.dest_en) begin
         first_ph = PH_DEST;
      end else begin
         first_ph = PH_STAT;
      end
      cur_ph  = started_ff ? phase_ff : first_ph;
      cur_v   = started_ff ? v_ff : head.mark_start;
      cur_rem = started_ff ? rem_ff : head.mark_cnt;
   end

   // next phase after the current word
   always_comb begin
      nxt_ph = PH_STAT;
      more   = 1'b0;
      case (cur_ph)
         PH_MARK: begin
            if (cur_rem > RUN_W'(1)) begin
               nxt_ph = PH_MARK;
               more   = 1'b1;
            end else if (head.time_en) begin
               nxt_ph = PH_TIME;
               more   = 1'b1;
            end else if (head.dest_en) begin
               nxt_ph = PH_DEST;
               more   = 1'b1;
            end else if (head.stat_en) begin
               nxt_ph = PH_STAT;
               more   = 1'b1;
            end
         end
         PH_TIME: begin
            if (head.dest_en) begin
               nxt_ph = PH_DEST;
               more   = 1'b1;
            end else if (head.stat_en) begin
               nxt_ph = PH_STAT;
               more   = 1'b1;
            end
         end
         PH_DEST: begin
            if (head.stat_en) begin
               nxt_ph = PH_STAT;
               more   = 1'b1;
            end
         end
         default: begin
            more = 1'b0;
         end
      endcase
   end

   // progress through the command
   always_comb begin
      started_in = started_ff;
      phase_in   = phase_ff;
      v_in       = v_ff;
      rem_in     = rem_ff;
      if (emit) begin
         started_in = more;
         phase_in   = nxt_ph;
         v_in       = cur_v + NODE_W'(1);
         rem_in     = cur_rem - RUN_W'(1);
      end
   end

   // result word for the current phase
   always_comb begin
      counts   = (cur_ph != PH_STAT);
      wcnt_inc = (wcnt_ff == '1) ? wcnt_ff : wcnt_ff + WORD_W'(1);
      rsp_in             = rsp_ff;
      rsp_in.last        = !more;
      rsp_in.resend      = head.again;
      rsp_in.done_res    = 1'b0;
      rsp_in.error       = ERR_NONE;
      rsp_in.total_words = counts ? wcnt_inc : wcnt_ff;
      case (cur_ph)
         PH_MARK: begin
            rsp_in.kind = KIND_MARK;
            rsp_in.word = $signed(~{{(WORD_W-NODE_W){1'b0}}, cur_v});
         end
         PH_TIME: begin
            rsp_in.kind = KIND_TIME;
            rsp_in.word = $signed(head.time_word);
         end
         PH_DEST: begin
            rsp_in.kind = KIND_DEST;
            rsp_in.word = $signed({{(WORD_W-NODE_W){1'b0}}, head.dest});
         end
         default: begin
            rsp_in.kind     = KIND_STAT;
            rsp_in.word     = '0;
            rsp_in.done_res = head.done;
            rsp_in.error    = head.err;
         end
      endcase
      wcnt_in      = (emit && counts) ? wcnt_inc : wcnt_ff;
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         phase_ff     <= PH_MARK;
         wcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff   <= started_in;
         phase_ff     <= phase_in;
         wcnt_ff      <= wcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      rem_ff <= rem_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
